FILE: sv/tmm_pkg.sv
package tmm_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS    = 30;
	localparam int TRIG_W          = 34;
	localparam int PHASE_W         = 32;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;

	typedef logic signed [TRIG_W-1:0] trig_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} sincos_t;

	function automatic logic signed [PHASE_W+1:0] atan_turns(input int i);
		logic [31:0] t;
		begin
			case (i)
				0: t = 32'h20000000;  1: t = 32'h12e4051d;  2: t = 32'h09fb385b;
				3: t = 32'h051111d4;  4: t = 32'h028b0d43;  5: t = 32'h0145d7e1;
				6: t = 32'h00a2f61e;  7: t = 32'h00517c55;  8: t = 32'h0028be53;
				9: t = 32'h00145f2e; 10: t = 32'h000a2f98; 11: t = 32'h000517cc;
				12: t = 32'h00028be6; 13: t = 32'h000145f3; 14: t = 32'h0000a2f9;
				15: t = 32'h0000517c; 16: t = 32'h000028be; 17: t = 32'h0000145f;
				18: t = 32'h00000a2f; 19: t = 32'h00000517; 20: t = 32'h0000028b;
				21: t = 32'h00000145; 22: t = 32'h000000a2; 23: t = 32'h00000051;
				24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000a;
				27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
				default: t = 32'h0;
			endcase
			atan_turns = $signed({2'b00, t});
		end
	endfunction

	// Q4.30 (34-bit signed, 30 fraction bits) product floored back to Q4.30.
	function automatic trig_t qmul(input trig_t a, input trig_t b);
		logic signed [2*TRIG_W-1:0] p;
		begin
			p = a * b;
			qmul = p[TRIG_W+29:30];
		end
	endfunction

endpackage

FILE: sv/tmm_sincos.sv
module tmm_sincos import tmm_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [ANGLE_WIDTH-1:0] angle,
	output sincos_t                result
);

	localparam int N = CORDIC_STEPS;

	trig_t                     x_s [N+1];
	trig_t                     y_s [N+1];
	logic signed [PHASE_W+1:0] z_s [N+1];
	logic [1:0]                q_s [N+1];

	logic [PHASE_W-1:0] phase;
	logic [PHASE_W-1:0] resid;

	assign phase = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};
	assign resid = phase - {q_s[0], 30'd0};

	always_comb begin
		q_s[0] = phase[31:30] + {1'b0, phase[29]};
		x_s[0] = CORDIC_GAIN_INV;
		y_s[0] = '0;
		z_s[0] = {{2{resid[31]}}, resid};
	end

	// One rotation step per stage; the final stage applies the quadrant.
	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turns(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turns(i);
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N])
				2'd0: begin result.c <= x_s[N];  result.s <= y_s[N];  end
				2'd1: begin result.c <= -y_s[N]; result.s <= x_s[N];  end
				2'd2: begin result.c <= -x_s[N]; result.s <= -y_s[N]; end
				default: begin result.c <= y_s[N]; result.s <= -x_s[N]; end
			endcase
		end
	end

	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

FILE: sv/tmm_scale.sv
module tmm_scale import tmm_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [VALUE_WIDTH-1:0] sc,
	input  trig_t                         r,
	output logic signed [VALUE_WIDTH-1:0] entry
);

	localparam int PW = VALUE_WIDTH + TRIG_W;
	localparam logic signed [PW-1:0] MAXV = PW'((64'd1 << (VALUE_WIDTH-1)) - 1);
	localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

	logic signed [PW-1:0] p_s1;
	logic signed [PW-1:0] t_c;

	always_comb begin
		// Truncate toward zero: add 2^30-1 for negative products before the shift.
		t_c = $signed(p_s1 + (p_s1[PW-1] ? PW'(30'h3FFFFFFF) : PW'(0))) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= PW'(sc) * PW'(r);
			if (t_c > MAXV)
				entry <= MAXV[VALUE_WIDTH-1:0];
			else if (t_c < MINV)
				entry <= MINV[VALUE_WIDTH-1:0];
			else
				entry <= t_c[VALUE_WIDTH-1:0];
		end
	end

endmodule

FILE: sv/trs_model_matrix.sv
// Model matrix builder: one item per cycle, start accepted whenever busy is low
// (busy is always low). Each item yields one strobed result after 31 CORDIC
// stages for sine and cosine, three rotation product stages and two scale
// multiply/saturate stages. The receiver cannot stall; results are presented
// for exactly one cycle with done high.
module trs_model_matrix import tmm_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic signed [VALUE_WIDTH-1:0] pos_x,
	input  logic signed [VALUE_WIDTH-1:0] pos_y,
	input  logic signed [VALUE_WIDTH-1:0] pos_z,
	input  logic [ANGLE_WIDTH-1:0]        pitch_angle,
	input  logic [ANGLE_WIDTH-1:0]        yaw_angle,
	input  logic [ANGLE_WIDTH-1:0]        roll_angle,
	input  logic signed [VALUE_WIDTH-1:0] scale_x,
	input  logic signed [VALUE_WIDTH-1:0] scale_y,
	input  logic signed [VALUE_WIDTH-1:0] scale_z,
	output logic signed [VALUE_WIDTH-1:0] m00, m01, m02, m03,
	output logic signed [VALUE_WIDTH-1:0] m10, m11, m12, m13,
	output logic signed [VALUE_WIDTH-1:0] m20, m21, m22, m23
);

	localparam int TRIG_LAT = CORDIC_STEPS + 1;
	localparam int LAT      = TRIG_LAT + 3 + 2;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef struct packed {
		val_t px, py, pz, sx, sy, sz;
	} side_t;

	logic  vld_q [LAT+1];
	side_t side_q [LAT+1];
	logic  en;

	assign busy = 1'b0;
	assign en   = 1'b1;
	assign vld_q[0]  = start;
	assign side_q[0] = '{pos_x, pos_y, pos_z, scale_x, scale_y, scale_z};

	for (genvar k = 0; k < LAT; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k+1] <= 1'b0;
			else vld_q[k+1] <= vld_q[k];
		end
		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	sincos_t p_tr, y_tr, r_tr;

	tmm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_p (.clk, .arst_n, .en,
		.angle(pitch_angle), .result(p_tr));
	tmm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_y (.clk, .arst_n, .en,
		.angle(yaw_angle), .result(y_tr));
	tmm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_r (.clk, .arst_n, .en,
		.angle(roll_angle), .result(r_tr));

	// Stage A: two-factor products; carry sines and cosines forward.
	trig_t cp_s1, sp_s1, cy_s1, sy_s1, cr_s1, sr_s1;
	trig_t spsy_s1, spcy_s1, crcy_s1, crsy_s1, srcy_s1, srsy_s1;
	trig_t srcp_s1, crcp_s1, cpsy_s1, cpcy_s1;
	always_ff @(posedge clk) begin
		cp_s1 <= p_tr.c; sp_s1 <= p_tr.s; cy_s1 <= y_tr.c; sy_s1 <= y_tr.s;
		cr_s1 <= r_tr.c; sr_s1 <= r_tr.s;
		spsy_s1 <= qmul(p_tr.s, y_tr.s);
		spcy_s1 <= qmul(p_tr.s, y_tr.c);
		crcy_s1 <= qmul(r_tr.c, y_tr.c);
		crsy_s1 <= qmul(r_tr.c, y_tr.s);
		srcy_s1 <= qmul(r_tr.s, y_tr.c);
		srsy_s1 <= qmul(r_tr.s, y_tr.s);
		srcp_s1 <= qmul(r_tr.s, p_tr.c);
		crcp_s1 <= qmul(r_tr.c, p_tr.c);
		cpsy_s1 <= qmul(p_tr.c, y_tr.s);
		cpcy_s1 <= qmul(p_tr.c, y_tr.c);
	end

	// Stage B: three-factor products; carry the other rotation terms forward.
	trig_t a00_s2, a02_s2, a10_s2, a12_s2;
	trig_t c00_s2, c02_s2, c10_s2, c12_s2;
	trig_t r01_s2, r11_s2, r20_s2, r21_s2, r22_s2;
	always_ff @(posedge clk) begin
		a00_s2 <= crcy_s1; a02_s2 <= crsy_s1; a10_s2 <= srcy_s1; a12_s2 <= srsy_s1;
		c00_s2 <= qmul(sr_s1, spsy_s1);
		c02_s2 <= qmul(sr_s1, spcy_s1);
		c10_s2 <= qmul(cr_s1, spsy_s1);
		c12_s2 <= qmul(cr_s1, spcy_s1);
		r01_s2 <= -srcp_s1; r11_s2 <= crcp_s1; r20_s2 <= -cpsy_s1;
		r21_s2 <= sp_s1; r22_s2 <= cpcy_s1;
	end

	// Stage C: sums.
	trig_t rot_s3 [9];
	always_ff @(posedge clk) begin
		rot_s3[0] <= a00_s2 - c00_s2;
		rot_s3[1] <= r01_s2;
		rot_s3[2] <= a02_s2 + c02_s2;
		rot_s3[3] <= a10_s2 + c10_s2;
		rot_s3[4] <= r11_s2;
		rot_s3[5] <= a12_s2 - c12_s2;
		rot_s3[6] <= r20_s2;
		rot_s3[7] <= r21_s2;
		rot_s3[8] <= r22_s2;
	end

	side_t sd;
	assign sd = side_q[TRIG_LAT+3];
	val_t ent [9];
	for (genvar e = 0; e < 9; e++) begin : g_sc
		val_t scv;
		assign scv = (e % 3 == 0) ? sd.sx : ((e % 3 == 1) ? sd.sy : sd.sz);
		tmm_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_sc (.clk, .en, .sc(scv),
			.r(rot_s3[e]), .entry(ent[e]));
	end

	side_t so;
	assign so   = side_q[LAT];
	assign done = vld_q[LAT];
	assign m00 = ent[0]; assign m01 = ent[1]; assign m02 = ent[2]; assign m03 = so.px;
	assign m10 = ent[3]; assign m11 = ent[4]; assign m12 = ent[5]; assign m13 = so.py;
	assign m20 = ent[6]; assign m21 = ent[7]; assign m22 = ent[8]; assign m23 = so.pz;

endmodule

FILE: dv/trs_model_matrix_tb.sv
module trs_model_matrix_tb;
	import tmm_pkg::*;

	localparam int VW = 32;
	localparam int AW = 16;
	localparam int LATENCY = 36;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [VW-1:0] px, py, pz;
		logic [AW-1:0] pitch, yaw, roll;
		logic signed [VW-1:0] sx, sy, sz;
	} pose_t;

	typedef struct {
		logic signed [VW-1:0] m [12];
	} matrix_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic signed [VW-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [AW-1:0] pitch_angle = 0, yaw_angle = 0, roll_angle = 0;
	logic signed [VW-1:0] scale_x = 0, scale_y = 0, scale_z = 0;
	logic signed [VW-1:0] m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23;

	pose_t pending_poses[$];
	matrix_t expected_matrices[$];
	int mismatches = 0;
	int cycles = 0;
	int gap = 0;
	bit stimulus_done = 0;

	trs_model_matrix uut (.*);

	always #2 clk = ~clk;

	// Floor of v / 2^s, matching an arithmetic shift.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint trig_mul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic void cordic_sincos(logic [AW-1:0] ang, output longint c,
			output longint s);
		longint atan_tab [30] = '{
			'h20000000, 'h12e4051d, 'h09fb385b, 'h051111d4, 'h028b0d43,
			'h0145d7e1, 'h00a2f61e, 'h00517c55, 'h0028be53, 'h00145f2e,
			'h000a2f98, 'h000517cc, 'h00028be6, 'h000145f3, 'h0000a2f9,
			'h0000517c, 'h000028be, 'h0000145f, 'h00000a2f, 'h00000517,
			'h0000028b, 'h00000145, 'h000000a2, 'h00000051, 'h00000028,
			'h00000014, 'h0000000a, 'h00000005, 'h00000002, 'h00000001};
		logic [31:0] phase;
		logic [31:0] quad;
		longint z, x, y, nx;
		phase = {ang, {(32 - AW){1'b0}}};
		quad = ((phase + 32'h20000000) >> 30) & 3;
		z = longint'(phase) - longint'(quad) * 64'h40000000;
		if (z >= 64'sh80000000) z = z - 64'sh100000000;
		x = 'h26DD3B6A;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= atan_tab[i];
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += atan_tab[i];
			end
			x = nx;
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	// Product truncated toward zero by 30 bits, then saturated.
	function automatic logic signed [VW-1:0] scaled_entry(longint sc, longint r);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = 128'(sc) * 128'(r);
		q = (p < 0) ? -((-p) >>> 30) : (p >>> 30);
		if (q > 128'sd2147483647) return 32'sh7fffffff;
		if (q < -128'sd2147483648) return 32'sh80000000;
		return q[VW-1:0];
	endfunction

	function automatic matrix_t build_matrix(pose_t p);
		matrix_t m;
		longint cp, sp, cy, sy, cr, sr;
		longint rot [9];
		longint sc [3];
		cordic_sincos(p.pitch, cp, sp);
		cordic_sincos(p.yaw, cy, sy);
		cordic_sincos(p.roll, cr, sr);
		sc[0] = p.sx; sc[1] = p.sy; sc[2] = p.sz;
		rot[0] = trig_mul(cr, cy) - trig_mul(sr, trig_mul(sp, sy));
		rot[1] = -trig_mul(sr, cp);
		rot[2] = trig_mul(cr, sy) + trig_mul(sr, trig_mul(sp, cy));
		rot[3] = trig_mul(sr, cy) + trig_mul(cr, trig_mul(sp, sy));
		rot[4] = trig_mul(cr, cp);
		rot[5] = trig_mul(sr, sy) - trig_mul(cr, trig_mul(sp, cy));
		rot[6] = -trig_mul(cp, sy);
		rot[7] = sp;
		rot[8] = trig_mul(cp, cy);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				m.m[r * 4 + c] = scaled_entry(sc[c], rot[r * 3 + c]);
		m.m[3] = p.px; m.m[7] = p.py; m.m[11] = p.pz;
		return m;
	endfunction

	function automatic logic [31:0] rand_value(int mode);
		case (mode)
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h00010000;
			3: return 32'hffff0000;
			4: return $urandom_range(0, 'h3ffff) - 'h20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.px = $urandom; p.py = $urandom; p.pz = $urandom;
		p.pitch = AW'($urandom); p.yaw = AW'($urandom); p.roll = AW'($urandom);
		p.sx = rand_value($urandom_range(0, 7));
		p.sy = rand_value($urandom_range(0, 7));
		p.sz = rand_value($urandom_range(0, 7));
		return p;
	endfunction

	function automatic pose_t make_pose(logic [AW-1:0] a, logic [AW-1:0] b,
			logic [AW-1:0] c, logic [31:0] s, logic [31:0] t);
		pose_t p;
		p.px = t; p.py = ~t; p.pz = t ^ 32'h5a5a5a5a;
		p.pitch = a; p.yaw = b; p.roll = c;
		p.sx = s; p.sy = s; p.sz = s;
		return p;
	endfunction

	initial begin
		pose_t p;
		// Directed: zero, quadrant edges, full-turn wrap, extreme scales and positions.
		pending_poses.push_back(make_pose(16'h0, 16'h0, 16'h0, 32'h00010000, 32'h0));
		pending_poses.push_back(make_pose(16'hffff, 16'hffff, 16'hffff, 32'h7fffffff,
			32'h7fffffff));
		pending_poses.push_back(make_pose(16'h4000, 16'h0, 16'h0, 32'h80000000,
			32'h80000000));
		pending_poses.push_back(make_pose(16'h0, 16'h4000, 16'h0, 32'h7fffffff,
			32'hffffffff));
		pending_poses.push_back(make_pose(16'h0, 16'h0, 16'h4000, 32'h80000000, 32'h1));
		pending_poses.push_back(make_pose(16'h8000, 16'h8000, 16'h8000, 32'h7fffffff, 32'h0));
		pending_poses.push_back(make_pose(16'hc000, 16'hc000, 16'hc000, 32'h80000000, 32'h0));
		pending_poses.push_back(make_pose(16'h2000, 16'h2000, 16'h2000, 32'h00010000, 32'h0));
		pending_poses.push_back(make_pose(16'h1fff, 16'h6000, 16'ha000, 32'hffff0000, 32'h0));
		pending_poses.push_back(make_pose(16'he000, 16'h5fff, 16'h3fff, 32'h0, 32'h12345678));
		pending_poses.push_back(make_pose(16'h0001, 16'h7fff, 16'hbfff, 32'hffffffff, 32'h0));
		pending_poses.push_back(make_pose(16'h2aaa, 16'h5555, 16'haaaa, 32'h40000000, 32'h0));
		pending_poses.push_back(make_pose(16'h8001, 16'h4001, 16'hc001, 32'hc0000000, 32'h0));
		for (int i = 0; i < 1540; i++) begin
			p = rand_pose();
			pending_poses.push_back(p);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// Driver
	always @(posedge clk) begin
		pose_t p;
		if (arst_n) begin
			if (start && !busy) begin
				expected_matrices.push_back(build_matrix('{pos_x, pos_y, pos_z,
					pitch_angle, yaw_angle, roll_angle, scale_x, scale_y, scale_z}));
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 99) < 30) gap = 0;
			end
			if (start && !busy || !start) begin
				if (gap > 0 || pending_poses.size() == 0) begin
					start <= 0;
					if (gap > 0) gap = gap - 1;
					if (pending_poses.size() == 0) stimulus_done <= 1;
				end else begin
					p = pending_poses.pop_front();
					start <= 1;
					pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
					pitch_angle <= p.pitch; yaw_angle <= p.yaw; roll_angle <= p.roll;
					scale_x <= p.sx; scale_y <= p.sy; scale_z <= p.sz;
				end
			end
		end
	end

	// Monitor
	always @(posedge clk) begin
		matrix_t e;
		logic signed [VW-1:0] got [12];
		bit bad;
		if (arst_n && done) begin
			got = '{m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23};
			if (expected_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item m00=%h", m00);
			end else begin
				e = expected_matrices.pop_front();
				bad = 0;
				for (int k = 0; k < 12; k++)
					if (got[k] !== e.m[k]) begin
						bad = 1;
						if (mismatches < 10)
							$display("entry m%0d%0d: expected %h got %h", k / 4, k % 4,
								e.m[k], got[k]);
					end
				if (bad) mismatches++;
			end
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_matrices.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
